/* hdl/pidpc_pkg.sv */
// Shared constants, register codes and types for the PID position controller.
`default_nettype none

package pidpc_pkg;

   // Fixed-point format of the gains and width of the integral accumulator
   localparam int GAIN_FRAC_BITS = 16;
   localparam int INTEG_WIDTH    = 32;

   // Field widths
   localparam int POS_W    = 16;
   localparam int ERR_W    = POS_W + 1;
   localparam int DERIV_W  = ERR_W + 1;
   localparam int GAIN_W   = 24;
   localparam int WINDOW_W = 16;
   localparam int LIMIT_W  = 15;
   localparam int DRIVE_W  = LIMIT_W + 1;

   // Product widths: unsigned gain extended by one sign bit times a signed operand
   localparam int PROP_PROD_W  = GAIN_W + 1 + ERR_W;
   localparam int INTEG_PROD_W = GAIN_W + 1 + INTEG_WIDTH;
   localparam int DERIV_PROD_W = GAIN_W + 1 + DERIV_W;
   localparam int SUM_W        = INTEG_PROD_W + 2;

   // Configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = GAIN_W;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PROP_GAIN    = 3'd0,
      CSR_INTEG_GAIN   = 3'd1,
      CSR_DERIV_GAIN   = 3'd2,
      CSR_INTEG_WINDOW = 3'd3,
      CSR_DRIVE_LIMIT  = 3'd4
   } csr_index_type;

   // Register reset values
   localparam logic [GAIN_W-1:0]   PROP_GAIN_RST    = 24'd327680;
   localparam logic [GAIN_W-1:0]   INTEG_GAIN_RST   = 24'd2621;
   localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST   = 24'd0;
   localparam logic [WINDOW_W-1:0] INTEG_WINDOW_RST = 16'd50;
   localparam logic [LIMIT_W-1:0]  DRIVE_LIMIT_RST  = 15'd127;

   // One result word, as handed from the clamp stage to the output register
   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      clamped;
   } result_type;

endpackage

`default_nettype wire

/* hdl/pid_position_controller.sv */
// Top level of the PID position controller: error, integral window, gains and clamp.
// Path from the accepting req edge to rsp_tvalid: state and input register,
//   product register, sum register, then clamp into the output register.
// Throughput: one word per cycle unless rsp stalls; the integral and last-error
//   update is a single add and saturate at the input, so items follow back to back.
// Backpressure on rsp stalls the whole pipeline; bubbles are squeezed out.
// Reset (synchronous, active high) restores the register defaults, clears the
//   integral and last error and empties the pipeline.
`default_nettype none

module pid_position_controller (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // req_tdata: position [15:0], target [31:16]
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [31:0]                         req_tdata,
   // rsp_tdata: drive [15:0]
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [15:0]                              rsp_tdata,
   // rsp_tuser: clamped [0]
   output logic                                     rsp_tuser,
   input  wire logic                                csr_wen,
   input  wire logic [pidpc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [pidpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // ---------------------------------------------------------------- registers
   logic [pidpc_pkg::GAIN_W-1:0]   prop_gain_ff;
   logic [pidpc_pkg::GAIN_W-1:0]   integ_gain_ff;
   logic [pidpc_pkg::GAIN_W-1:0]   deriv_gain_ff;
   logic [pidpc_pkg::WINDOW_W-1:0] integ_window_ff;
   logic [pidpc_pkg::LIMIT_W-1:0]  drive_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff    <= pidpc_pkg::PROP_GAIN_RST;
         integ_gain_ff   <= pidpc_pkg::INTEG_GAIN_RST;
         deriv_gain_ff   <= pidpc_pkg::DERIV_GAIN_RST;
         integ_window_ff <= pidpc_pkg::INTEG_WINDOW_RST;
         drive_limit_ff  <= pidpc_pkg::DRIVE_LIMIT_RST;
      end else if (csr_wen) begin
         unique case (pidpc_pkg::csr_index_type'(csr_index))
            pidpc_pkg::CSR_PROP_GAIN:    prop_gain_ff  <= csr_wdata;
            pidpc_pkg::CSR_INTEG_GAIN:   integ_gain_ff <= csr_wdata;
            pidpc_pkg::CSR_DERIV_GAIN:   deriv_gain_ff <= csr_wdata;
            pidpc_pkg::CSR_INTEG_WINDOW:
               integ_window_ff <= csr_wdata[pidpc_pkg::WINDOW_W-1:0];
            pidpc_pkg::CSR_DRIVE_LIMIT:
               drive_limit_ff  <= csr_wdata[pidpc_pkg::LIMIT_W-1:0];
            default: ; // unused index: drop the write
         endcase
      end
   end

   // ---------------------------------------------------------------- flow control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic out_free, s3_free, s2_free, s1_free;
   logic req_accept;

   // A stage may load when it is empty or its word moves on this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s3_free    = !s3_valid_ff || out_free;
   assign s2_free    = !s2_valid_ff || s3_free;
   assign s1_free    = !s1_valid_ff || s2_free;
   assign req_tready = s1_free;
   assign req_accept = req_tvalid && s1_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_free)  s1_valid_ff  <= req_tvalid;
         if (s2_free)  s2_valid_ff  <= s1_valid_ff;
         if (s3_free)  s3_valid_ff  <= s2_valid_ff;
         if (out_free) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // ---------------------------------------------------------------- stage 1
   // Error, derivative and the windowed, saturating integral. The loop state
   // advances on every accepted word so the next word sees it at once.
   logic signed [pidpc_pkg::POS_W-1:0]       position, target;
   logic signed [pidpc_pkg::ERR_W-1:0]       err_in;
   logic signed [pidpc_pkg::DERIV_W-1:0]     deriv_in;
   logic        [pidpc_pkg::ERR_W-1:0]       abs_err;
   logic                                     integ_on;
   logic signed [pidpc_pkg::INTEG_WIDTH:0]   integ_wide;
   logic signed [pidpc_pkg::INTEG_WIDTH-1:0] integ_sum_in;

   logic signed [pidpc_pkg::ERR_W-1:0]       prev_error_ff;
   logic signed [pidpc_pkg::INTEG_WIDTH-1:0] integ_sum_ff;

   logic signed [pidpc_pkg::ERR_W-1:0]       s1_err_ff;
   logic signed [pidpc_pkg::DERIV_W-1:0]     s1_deriv_ff;
   logic signed [pidpc_pkg::INTEG_WIDTH-1:0] s1_integ_ff;

   always_comb begin
      position = $signed(req_tdata[15:0]);
      target   = $signed(req_tdata[31:16]);
      err_in   = pidpc_pkg::ERR_W'(target) - pidpc_pkg::ERR_W'(position);
      deriv_in = pidpc_pkg::DERIV_W'(err_in) - pidpc_pkg::DERIV_W'(prev_error_ff);
      abs_err  = err_in[pidpc_pkg::ERR_W-1] ? (~err_in + 1'b1) : err_in;
      integ_on = (integ_gain_ff != '0) &&
                 (abs_err < pidpc_pkg::ERR_W'(integ_window_ff));
      integ_wide = (pidpc_pkg::INTEG_WIDTH + 1)'(integ_sum_ff) +
                   (pidpc_pkg::INTEG_WIDTH + 1)'(err_in);
      if (!integ_on) begin
         integ_sum_in = '0;
      end else if (integ_wide[pidpc_pkg::INTEG_WIDTH] !=
                   integ_wide[pidpc_pkg::INTEG_WIDTH-1]) begin
         // overflow: hold at the signed limit in the direction of the sum
         integ_sum_in = integ_wide[pidpc_pkg::INTEG_WIDTH] ?
                        {1'b1, {(pidpc_pkg::INTEG_WIDTH-1){1'b0}}} :
                        {1'b0, {(pidpc_pkg::INTEG_WIDTH-1){1'b1}}};
      end else begin
         integ_sum_in = integ_wide[pidpc_pkg::INTEG_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         integ_sum_ff  <= '0;
      end else if (req_accept) begin
         prev_error_ff <= err_in;
         integ_sum_ff  <= integ_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_err_ff   <= err_in;
         s1_deriv_ff <= deriv_in;
         s1_integ_ff <= integ_sum_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // Three parallel gain products; gains are unsigned, so extend by a zero bit.
   logic signed [pidpc_pkg::PROP_PROD_W-1:0]  s2_prop_ff;
   logic signed [pidpc_pkg::INTEG_PROD_W-1:0] s2_integ_ff;
   logic signed [pidpc_pkg::DERIV_PROD_W-1:0] s2_deriv_ff;

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_prop_ff  <= $signed({1'b0, prop_gain_ff})  * s1_err_ff;
         s2_integ_ff <= $signed({1'b0, integ_gain_ff}) * s1_integ_ff;
         s2_deriv_ff <= $signed({1'b0, deriv_gain_ff}) * s1_deriv_ff;
      end
   end

   // ---------------------------------------------------------------- stage 3
   logic signed [pidpc_pkg::SUM_W-1:0] s3_sum_ff;

   always_ff @(posedge clock) begin
      if (s3_free && s2_valid_ff) begin
         s3_sum_ff <= pidpc_pkg::SUM_W'(s2_prop_ff) +
                      pidpc_pkg::SUM_W'(s2_integ_ff) +
                      pidpc_pkg::SUM_W'(s2_deriv_ff);
      end
   end

   // ---------------------------------------------------------------- stage 4
   pidpc_pkg::result_type clamp_result;
   pidpc_pkg::result_type rsp_ff;

   pidpc_clamp u_clamp (
      .sum    (s3_sum_ff),
      .limit  (drive_limit_ff),
      .result (clamp_result)
   );

   // Output register: holds a finished word while rsp is stalled
   always_ff @(posedge clock) begin
      if (out_free && s3_valid_ff) begin
         rsp_ff <= clamp_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.drive;
   assign rsp_tuser  = rsp_ff.clamped;

endmodule

`default_nettype wire

/* hdl/pidpc_clamp.sv */
// Truncate the gain sum toward zero, drop the fraction bits and clamp to the drive limit.
`default_nettype none

module pidpc_clamp (
   input  wire logic signed [pidpc_pkg::SUM_W-1:0]   sum,
   input  wire logic        [pidpc_pkg::LIMIT_W-1:0] limit,
   output pidpc_pkg::result_type                     result
);

   logic                             neg;
   logic [pidpc_pkg::SUM_W-1:0]      abs_sum;
   logic [pidpc_pkg::SUM_W-1:0]      mag;
   logic                             over;
   logic [pidpc_pkg::LIMIT_W-1:0]    mag_clip;
   logic [pidpc_pkg::DRIVE_W-1:0]    mag_ext;

   always_comb begin
      neg      = sum[pidpc_pkg::SUM_W-1];
      abs_sum  = neg ? (~sum + 1'b1) : sum;
      // shift the magnitude so the drop of fraction bits truncates toward zero
      mag      = abs_sum >> pidpc_pkg::GAIN_FRAC_BITS;
      over     = mag > pidpc_pkg::SUM_W'(limit);
      mag_clip = over ? limit : mag[pidpc_pkg::LIMIT_W-1:0];
      mag_ext  = {1'b0, mag_clip};
      result.drive   = neg ? $signed(~mag_ext + 1'b1) : $signed(mag_ext);
      result.clamped = over;
   end

endmodule

`default_nettype wire

/* test/tb_pid_position_controller.sv */
// Self-checking testbench for the PID position controller: drive prediction and stream checks.
`timescale 1ns / 1ps

module tb_pid_position_controller;

   // Pipeline depth from the accepting req edge to rsp_tvalid
   localparam int LATENCY = 3;
   // Cycles without any accepted word before the run is declared hung
   localparam int WATCHDOG_LIMIT = 2000;
   // Words in each random phase and number of phases
   localparam int PHASE_WORDS = 105;
   localparam int PHASES = 8;
   // Steady-error words used to ramp the integral
   localparam int RAMP_WORDS = 40;
   // Register index outside the map; writes to it must be ignored
   localparam logic [pidpc_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   localparam logic [pidpc_pkg::GAIN_W-1:0]   GAIN_MAX   = 24'hFFFFFF;
   localparam logic [pidpc_pkg::WINDOW_W-1:0] WINDOW_MAX = 16'hFFFF;
   localparam logic [pidpc_pkg::LIMIT_W-1:0]  LIMIT_MAX  = 15'h7FFF;
   localparam logic signed [15:0]  POS_MIN    = -16'sd32768;
   localparam logic signed [15:0]  POS_MAX    = 16'sd32767;

   // Drive predictor and store of expected drive words. Keeps its own copy of
   // the gain registers, the last error and the integral.
   class drive_checker;
      logic [pidpc_pkg::GAIN_W-1:0]               prop_gain, integ_gain, deriv_gain;
      logic [pidpc_pkg::WINDOW_W-1:0]             integ_window;
      logic [pidpc_pkg::LIMIT_W-1:0]              drive_limit;
      logic signed [pidpc_pkg::ERR_W-1:0]         last_error;
      logic signed [pidpc_pkg::INTEG_WIDTH-1:0]   integral;
      pidpc_pkg::result_type                      pending_drives[$];
      int                                         mismatches;
      int                                         noted;
      int                                         checked;

      function new();
         prop_gain    = pidpc_pkg::PROP_GAIN_RST;
         integ_gain   = pidpc_pkg::INTEG_GAIN_RST;
         deriv_gain   = pidpc_pkg::DERIV_GAIN_RST;
         integ_window = pidpc_pkg::INTEG_WINDOW_RST;
         drive_limit  = pidpc_pkg::DRIVE_LIMIT_RST;
         last_error   = '0;
         integral     = '0;
         mismatches   = 0;
         noted        = 0;
         checked      = 0;
      endfunction

      function void write_reg(logic [pidpc_pkg::CSR_INDEX_W-1:0] index,
                              logic [pidpc_pkg::CSR_DATA_W-1:0] value);
         case (index)
            pidpc_pkg::CSR_PROP_GAIN:    prop_gain    = value;
            pidpc_pkg::CSR_INTEG_GAIN:   integ_gain   = value;
            pidpc_pkg::CSR_DERIV_GAIN:   deriv_gain   = value;
            pidpc_pkg::CSR_INTEG_WINDOW: integ_window = value[pidpc_pkg::WINDOW_W-1:0];
            pidpc_pkg::CSR_DRIVE_LIMIT:  drive_limit  = value[pidpc_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      endfunction

      function pidpc_pkg::result_type predict_drive(logic signed [15:0] position,
                                                    logic signed [15:0] target);
         longint     pos_l, tgt_l, err, prev, deriv, abs_err, window, acc;
         longint     pg, ig, dg, integ_l, sum, drive, lim;
         longint     integ_hi, integ_lo;
         logic       clamped;
         pidpc_pkg::result_type res;
         pos_l    = longint'(position);
         tgt_l    = longint'(target);
         prev     = longint'(last_error);
         err      = tgt_l - pos_l;
         deriv    = err - prev;
         abs_err  = err < 0 ? -err : err;
         window   = longint'(integ_window);
         integ_hi = (longint'(1) <<< (pidpc_pkg::INTEG_WIDTH - 1)) - 1;
         integ_lo = -integ_hi - 1;
         // Integrate inside the window, clear outside or when the gain is zero
         if (integ_gain != '0 && abs_err < window) begin
            integ_l = longint'(integral);
            acc = integ_l + err;
            if (acc > integ_hi) acc = integ_hi;
            if (acc < integ_lo) acc = integ_lo;
            integral = acc[pidpc_pkg::INTEG_WIDTH-1:0];
         end else begin
            integral = '0;
         end
         last_error = err[pidpc_pkg::ERR_W-1:0];
         // All three products fit comfortably in 64 bits at these widths
         pg      = longint'(prop_gain);
         ig      = longint'(integ_gain);
         dg      = longint'(deriv_gain);
         integ_l = longint'(integral);
         sum     = pg * err + ig * integ_l + dg * deriv;
         // Truncate toward zero, then clamp symmetrically
         if (sum < 0) drive = -((-sum) >>> pidpc_pkg::GAIN_FRAC_BITS);
         else drive = sum >>> pidpc_pkg::GAIN_FRAC_BITS;
         lim     = longint'(drive_limit);
         clamped = 1'b0;
         if (drive > lim) begin
            drive   = lim;
            clamped = 1'b1;
         end
         if (drive < -lim) begin
            drive   = -lim;
            clamped = 1'b1;
         end
         res.drive   = drive[pidpc_pkg::DRIVE_W-1:0];
         res.clamped = clamped;
         return res;
      endfunction

      function void note_sample(logic signed [15:0] position, logic signed [15:0] target);
         pending_drives.push_back(predict_drive(position, target));
         noted++;
      endfunction

      function void report(string what, int expected, int actual);
         mismatches++;
         if (mismatches <= 10)
            $display("%t  %s: expected %0d, got %0d", $realtime, what, expected, actual);
      endfunction

      function void check_drive(logic [15:0] drive, logic clamped);
         pidpc_pkg::result_type exp;
         if (pending_drives.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t  rsp word with nothing pending: drive %0d", $realtime,
                        $signed(drive));
            return;
         end
         exp = pending_drives.pop_front();
         checked++;
         if (drive !== exp.drive) report("drive", int'(exp.drive), int'($signed(drive)));
         if (clamped !== exp.clamped) report("clamped", int'(exp.clamped), int'(clamped));
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [31:0]                       req_tdata;    // position [15:0], target [31:16]
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic [15:0]                       rsp_tdata;    // drive [15:0]
   logic                              rsp_tuser;    // clamped [0]
   logic                              csr_wen;
   logic [pidpc_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [pidpc_pkg::CSR_DATA_W-1:0]  csr_wdata;

   drive_checker sb = new();
   bit           no_idle;       // set during stretches with back-to-back words
   int           csr_writes;

   pid_position_controller u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Gap length: mostly none or short, now and then long
   function automatic int idle_gap();
      int r;
      r = int'($urandom_range(0, 99));
      if (r < 55) return 0;
      if (r < 90) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 30));
   endfunction

   // Present one word and hold it until accepted. Keep tvalid high when the
   // next word follows directly, so tvalid never drops and rises in one step.
   task automatic send_sample(input logic signed [15:0] position,
                              input logic signed [15:0] target);
      int gap;
      gap = no_idle ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {target, position};
      do @(posedge clock); while (req_tready !== 1'b1);
      sb.note_sample(position, target);
   endtask

   // End a burst of words: drop tvalid after the last handshake
   task automatic end_burst();
      req_tvalid <= 1'b0;
   endtask

   // Wait for every expected word, then let the pipeline settle
   task automatic drain();
      while (sb.pending_drives.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [pidpc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [pidpc_pkg::CSR_DATA_W-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(index, value);
      csr_writes++;
   endtask

   // Write all five registers, with junk above the window and limit widths, plus one
   // write to an unmapped index that must have no effect.
   task automatic set_config(input logic [pidpc_pkg::GAIN_W-1:0] pg,
                             input logic [pidpc_pkg::GAIN_W-1:0] ig,
                             input logic [pidpc_pkg::GAIN_W-1:0] dg,
                             input logic [pidpc_pkg::WINDOW_W-1:0] win,
                             input logic [pidpc_pkg::LIMIT_W-1:0] lim);
      logic [pidpc_pkg::CSR_DATA_W-1:0] w;
      write_reg(pidpc_pkg::CSR_PROP_GAIN, pg);
      write_reg(pidpc_pkg::CSR_INTEG_GAIN, ig);
      write_reg(pidpc_pkg::CSR_DERIV_GAIN, dg);
      w = pidpc_pkg::CSR_DATA_W'($urandom);
      w[pidpc_pkg::WINDOW_W-1:0] = win;
      write_reg(pidpc_pkg::CSR_INTEG_WINDOW, w);
      w = pidpc_pkg::CSR_DATA_W'($urandom);
      w[pidpc_pkg::LIMIT_W-1:0] = lim;
      write_reg(pidpc_pkg::CSR_DRIVE_LIMIT, w);
      write_reg(CSR_UNUSED_INDEX, pidpc_pkg::CSR_DATA_W'($urandom));
      csr_wen <= 1'b0;
   endtask

   function automatic logic [pidpc_pkg::GAIN_W-1:0] pick_gain();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return GAIN_MAX;
         2: return pidpc_pkg::GAIN_W'($urandom_range(0, 1 << pidpc_pkg::GAIN_FRAC_BITS));
         3: return pidpc_pkg::GAIN_W'($urandom_range(0, 1 << 20));
         default: return pidpc_pkg::GAIN_W'($urandom);
      endcase
   endfunction

   function automatic logic [pidpc_pkg::WINDOW_W-1:0] pick_window();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return WINDOW_MAX;
         2: return pidpc_pkg::WINDOW_W'($urandom_range(1, 300));
         default: return pidpc_pkg::WINDOW_W'($urandom);
      endcase
   endfunction

   function automatic logic [pidpc_pkg::LIMIT_W-1:0] pick_limit();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return LIMIT_MAX;
         2: return pidpc_pkg::LIMIT_W'($urandom_range(1, 1000));
         default: return pidpc_pkg::LIMIT_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [15:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return POS_MIN;
         1: return POS_MAX;
         2: return '0;
         3: return -16'sd1;
         default: return 16'($urandom);
      endcase
   endfunction

   // Random words: half of them track the target closely so the integral
   // window sees long runs of small errors; the rest are wide or extreme.
   task automatic run_random(input int count);
      int r, span, pos_i, tgt_i;
      logic signed [15:0] position, target;
      for (int i = 0; i < count; i++) begin
         r = int'($urandom_range(0, 99));
         position = 16'($urandom);
         if (r < 50) begin
            span  = sb.integ_window > 300 ? 300 : int'(sb.integ_window) + 2;
            pos_i = int'(position);
            tgt_i = pos_i + int'($urandom_range(0, 2 * span)) - span;
            if (tgt_i > 32767) tgt_i = 32767;
            if (tgt_i < -32768) tgt_i = -32768;
            target = tgt_i[15:0];
         end else if (r < 80) begin
            target = 16'($urandom);
         end else begin
            position = pick_extreme();
            target   = pick_extreme();
         end
         send_sample(position, target);
      end
      end_burst();
   endtask

   // Ramp the integral with a steady error just inside the window
   task automatic fill_integral(input logic signed [15:0] position,
                                input logic signed [15:0] target, input int count);
      for (int i = 0; i < count; i++) send_sample(position, target);
      end_burst();
   endtask

   // Result side: random stalls, mostly short, a few long, some long ready runs.
   // Sample at the edge, before any update from this edge lands.
   initial begin
      int hold;
      hold = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tready === 1'b1 && rsp_tvalid !== 1'b0)
            sb.check_drive(rsp_tdata, rsp_tuser);
         if (hold > 0) begin
            hold--;
         end else if (rsp_tready !== 1'b1) begin
            rsp_tready <= 1'b1;
            hold = $urandom_range(0, 9) == 0 ? int'($urandom_range(40, 120)) :
                                               int'($urandom_range(0, 6));
         end else begin
            rsp_tready <= 1'b0;
            hold = idle_gap();
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long
   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset === 1'b1 || csr_wen === 1'b1 ||
             (req_tvalid === 1'b1 && req_tready === 1'b1) ||
             (rsp_tvalid === 1'b1 && rsp_tready === 1'b1))
            idle = 0;
         else
            idle++;
      end
      $display("%t  no word accepted for %0d cycles", $realtime, WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
   end

   initial begin
      no_idle    = 1'b0;
      csr_writes = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_wen    <= 1'b0;
      csr_index  <= pidpc_pkg::CSR_PROP_GAIN;
      csr_wdata  <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset defaults: gain 5.0, integral 0.04, window 50, limit 127.
      // Cover small errors that integrate, the window edge and full-range errors.
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd10);
      send_sample(16'sd0, 16'sd49);
      send_sample(16'sd0, 16'sd50);
      send_sample(16'sd0, -16'sd49);
      send_sample(16'sd10, 16'sd0);
      send_sample(POS_MIN, POS_MAX);
      send_sample(POS_MAX, POS_MIN);
      send_sample(16'sd100, 16'sd100);
      send_sample(POS_MIN, POS_MIN);
      send_sample(POS_MAX, POS_MAX);
      send_sample(16'sd0, 16'sd1);
      end_burst();
      drain();

      // Zero limit and zero window with only the derivative term active:
      // drive stays 0 and flags any nonzero sum, derivative swings full range.
      set_config('0, '0, GAIN_MAX, '0, '0);
      send_sample(16'sd0, 16'sd0);
      send_sample(16'sd0, 16'sd1);
      send_sample(16'sd0, -16'sd1);
      send_sample(POS_MIN, POS_MAX);
      send_sample(POS_MAX, POS_MIN);
      end_burst();
      drain();

      // Every gain and both limits at their maximum
      set_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, WINDOW_MAX, LIMIT_MAX);
      send_sample(16'sd0, 16'sd5);
      send_sample(16'sd0, -16'sd5);
      send_sample(POS_MIN, 16'sd32766);
      send_sample(POS_MAX, -16'sd32767);
      end_burst();
      drain();

      // Integral ramp seen through a unit integral gain: hold the error one
      // below the widest window, back to back.
      no_idle = 1'b1;
      set_config('0, 24'd1, '0, WINDOW_MAX, LIMIT_MAX);
      fill_integral(POS_MIN, 16'sd32766, RAMP_WORDS);
      drain();
      // Keep the large integral under the largest integral gain
      set_config('0, GAIN_MAX, '0, WINDOW_MAX, LIMIT_MAX);
      fill_integral(16'sd0, 16'sd1, 4);
      drain();
      // One error outside the window clears the integral, then ramp negative
      set_config('0, 24'd1, '0, WINDOW_MAX, LIMIT_MAX);
      send_sample(POS_MIN, POS_MAX);
      fill_integral(16'sd32766, POS_MIN, RAMP_WORDS);
      drain();
      no_idle = 1'b0;

      // Random phases: all-zero gains, all-max, then mixed settings; two of
      // them run without sender gaps
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) set_config('0, '0, '0, pick_window(), pick_limit());
         else if (p == 1) set_config(GAIN_MAX, GAIN_MAX, GAIN_MAX, WINDOW_MAX, LIMIT_MAX);
         else set_config(pick_gain(), pick_gain(), pick_gain(), pick_window(), pick_limit());
         no_idle = (p == 3 || p == 6);
         run_random(PHASE_WORDS);
         drain();
      end

      $display("tb: %0d drive words checked against %0d sent, %0d register writes",
               sb.checked, sb.noted, csr_writes);
      $display("tb: covered window edges, zero limit and window, integral ramps both ways");
      if (sb.mismatches == 0 && sb.pending_drives.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d words still pending",
                  sb.mismatches, sb.pending_drives.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule
